>>> design/clseq_pkg.sv
// Shared types and constants for the command list sequencer.
`default_nettype none
package clseq_pkg;

    localparam int ADDR_BITS_DEFAULT = 19;
    localparam int FIELD_ADDR_W      = 19;
    localparam int WORD_W            = 16;
    localparam int INDEX_W           = 16;
    localparam int COUNT_W           = 16;

    localparam logic [COUNT_W-1:0] MAX_ENTRIES_RESET = 16'd2000;
    localparam int                 ENTRY_SIZE        = 32;
    localparam int                 LINK_SHIFT        = 3;

    // control word bit positions
    localparam int CTRL_END_BIT   = 15;
    localparam int CTRL_SKIP_BIT  = 14;
    localparam int CTRL_JUMP_HI   = 13;
    localparam int CTRL_JUMP_LO   = 12;
    localparam int CTRL_CODE_HI   = 3;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_MAX_ENTRIES = 3'd0;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_ENTRY = 1'b1
    } command_t;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_SKIPPED  = 3'd1,
        ACT_DRAW     = 3'd2,
        ACT_USR_CLIP = 3'd3,
        ACT_SYS_CLIP = 3'd4,
        ACT_LOCAL    = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_CONTINUE = 2'd0,
        ST_END      = 2'd1,
        ST_BAD      = 2'd2,
        ST_LIMIT    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        JMP_NEXT   = 2'd0,
        JMP_ASSIGN = 2'd1,
        JMP_CALL   = 2'd2,
        JMP_RETURN = 2'd3
    } jump_t;

    typedef enum logic [3:0] {
        CODE_USR_CLIP_A = 4'd8,
        CODE_SYS_CLIP   = 4'd9,
        CODE_LOCAL      = 4'd10,
        CODE_USR_CLIP_B = 4'd11
    } code_t;

    typedef struct packed {
        logic ret_valid;
        logic running;
        logic bad_seen;
    } clseq_flags_t;

    typedef struct packed {
        logic [INDEX_W-1:0]      table_index;
        action_t                 action;
        logic [FIELD_ADDR_W-1:0] next_address;
        status_t                 status;
        logic                    error_flag;
    } clseq_result_t;

    // 16 + 3 + 19 + 2 + 1 = 41 bits, padded to 48
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 48;

endpackage
`default_nettype wire

>>> design/command_list_sequencer.sv
// Command list sequencer top level: input register, walk state, result register.
//
// Usage:
//   Slave stream carries one item per beat: tuser is the command (0 start a
//   list, 1 fetched table entry); tdata carries start_address, control_word
//   and link_word. Master stream returns exactly one result beat per input
//   beat, in order: table_index, action, next_address, status, error_flag.
//   The APB port holds max_entries at address 0 (reset value 2000); write it
//   only while no beat is in flight.
//   A beat accepted into the input register is processed combinationally
//   and lands in the result register once that register can take it. While
//   the receiver keeps up, throughput is one beat per cycle; the walk
//   state updates as each item moves into the result register, so the next
//   item sees it with no bubble. A full walk step still costs one memory
//   round trip outside the block, since each fetch address comes from here.
//   Reset clears the walk state (no list running, no saved return, error
//   flag clear) and empties both registers.
//   When the receiver stalls, the held result stays put; one more input
//   beat is absorbed in the input register, then s_tready drops.
`default_nettype none
module command_list_sequencer #(
    parameter int ADDR_BITS = clseq_pkg::ADDR_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // APB configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [clseq_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [clseq_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [clseq_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                     pready,
    // input items
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [18:0] start_address, [34:19] control_word, [50:35] link_word, rest zero
    input  wire logic [clseq_pkg::IN_TDATA_W-1:0]    s_tdata,
    // [0] command
    input  wire logic                                s_tuser,
    // result items
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [15:0] table_index, [18:16] action, [37:19] next_address,
    // [39:38] status, [40] error_flag, rest zero
    output logic      [clseq_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import clseq_pkg::*;

    localparam int CTRL_LSB = FIELD_ADDR_W;
    localparam int LINK_LSB = FIELD_ADDR_W + WORD_W;

    logic [COUNT_W-1:0] max_entries;

    // input register
    logic                    in_valid_reg;
    logic                    in_valid_next;
    command_t                cmd_reg;
    logic [FIELD_ADDR_W-1:0] start_reg;
    logic [WORD_W-1:0]       ctrl_reg;
    logic [WORD_W-1:0]       link_reg;
    logic                    in_beat;
    logic                    advance;
    logic                    can_load;

    // walk state
    logic [ADDR_BITS-1:0] cur_addr_reg;
    logic [ADDR_BITS-1:0] cur_addr_next;
    logic [ADDR_BITS-1:0] ret_addr_reg;
    logic [ADDR_BITS-1:0] ret_addr_next;
    logic [COUNT_W-1:0]   entry_count_reg;
    logic [COUNT_W-1:0]   entry_count_next;
    clseq_flags_t         flags_reg;
    clseq_flags_t         flags_next;
    clseq_result_t        result;

    clseq_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .max_entries (max_entries)
    );

    assign advance  = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || can_load;
    assign in_beat  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_beat)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            cmd_reg   <= command_t'(s_tuser);
            start_reg <= s_tdata[FIELD_ADDR_W-1:0];
            ctrl_reg  <= s_tdata[CTRL_LSB +: WORD_W];
            link_reg  <= s_tdata[LINK_LSB +: WORD_W];
        end
    end

    clseq_step #(
        .ADDR_BITS (ADDR_BITS)
    ) u_step (
        .command          (cmd_reg),
        .start_address    (start_reg),
        .control_word     (ctrl_reg),
        .link_word        (link_reg),
        .max_entries      (max_entries),
        .cur_addr         (cur_addr_reg),
        .ret_addr         (ret_addr_reg),
        .entry_count      (entry_count_reg),
        .flags            (flags_reg),
        .cur_addr_next    (cur_addr_next),
        .ret_addr_next    (ret_addr_next),
        .entry_count_next (entry_count_next),
        .flags_next       (flags_next),
        .result           (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_addr_reg    <= '0;
            ret_addr_reg    <= '0;
            entry_count_reg <= '0;
            flags_reg       <= '0;
        end
        else if (advance)
        begin
            cur_addr_reg    <= cur_addr_next;
            ret_addr_reg    <= ret_addr_next;
            entry_count_reg <= entry_count_next;
            flags_reg       <= flags_next;
        end
    end

    clseq_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef ASSERT_OFF
    a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(cur_addr_reg) && $stable(entry_count_reg)
                     && $stable(flags_reg))
        else $error("walk state changed without an item retiring");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg.bad_seen |=> flags_reg.bad_seen)
        else $error("bad command flag cleared");

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        advance && cmd_reg == CMD_ENTRY && result.status == ST_CONTINUE
        |=> entry_count_reg == $past(entry_count_reg) + COUNT_W'(1))
        else $error("entry count did not advance on a processed entry");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("retired item produced no result beat");

    a_stop_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        advance && cmd_reg == CMD_ENTRY && result.status != ST_CONTINUE
        |=> !flags_reg.running)
        else $error("walk still running after a stop status");
`endif

endmodule
`default_nettype wire

>>> design/clseq_regs.sv
// APB configuration register block (max_entries).
`default_nettype none
module clseq_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [clseq_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [clseq_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [clseq_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                     pready,
    output logic      [clseq_pkg::COUNT_W-1:0]       max_entries
);
    import clseq_pkg::*;

    logic [COUNT_W-1:0] max_entries_reg;
    logic [COUNT_W-1:0] max_entries_next;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr == REG_MAX_ENTRIES);

    always_comb
    begin
        max_entries_next = max_entries_reg;
        if (wr_en)
        begin
            max_entries_next = pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MAX_ENTRIES_RESET;
        end
        else
        begin
            max_entries_reg <= max_entries_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_MAX_ENTRIES)
        begin
            prdata = APB_DATA_W'(max_entries_reg);
        end
    end

    assign max_entries = max_entries_reg;

endmodule
`default_nettype wire

>>> design/clseq_step.sv
// Entry classification, jump resolution and next walk state for one item.
`default_nettype none
module clseq_step #(
    parameter int ADDR_BITS = clseq_pkg::ADDR_BITS_DEFAULT
) (
    input  wire clseq_pkg::command_t                 command,
    input  wire logic [clseq_pkg::FIELD_ADDR_W-1:0]  start_address,
    input  wire logic [clseq_pkg::WORD_W-1:0]        control_word,
    input  wire logic [clseq_pkg::WORD_W-1:0]        link_word,
    input  wire logic [clseq_pkg::COUNT_W-1:0]       max_entries,
    input  wire logic [ADDR_BITS-1:0]                cur_addr,
    input  wire logic [ADDR_BITS-1:0]                ret_addr,
    input  wire logic [clseq_pkg::COUNT_W-1:0]       entry_count,
    input  wire clseq_pkg::clseq_flags_t             flags,
    output logic      [ADDR_BITS-1:0]                cur_addr_next,
    output logic      [ADDR_BITS-1:0]                ret_addr_next,
    output logic      [clseq_pkg::COUNT_W-1:0]       entry_count_next,
    output clseq_pkg::clseq_flags_t                  flags_next,
    output clseq_pkg::clseq_result_t                 result
);
    import clseq_pkg::*;

    logic [ADDR_BITS-1:0] seq_addr;
    logic [ADDR_BITS-1:0] link_addr;
    logic [ADDR_BITS-1:0] load_addr;
    logic [ADDR_BITS-1:0] target;
    logic [3:0]           code;
    jump_t                jump;
    action_t              act;
    logic                 bad_code;

    assign seq_addr   = cur_addr + ADDR_BITS'(ENTRY_SIZE);
    assign link_addr  = ADDR_BITS'({link_word, LINK_SHIFT'(0)});
    assign load_addr  = ADDR_BITS'(start_address);
    assign code       = control_word[CTRL_CODE_HI:0];
    assign jump       = jump_t'(control_word[CTRL_JUMP_HI:CTRL_JUMP_LO]);

    // action class of a processed entry
    always_comb
    begin
        bad_code = 1'b0;
        act      = ACT_DRAW;
        if (control_word[CTRL_SKIP_BIT])
        begin
            act = ACT_SKIPPED;
        end
        else if (!code[CTRL_CODE_HI])
        begin
            act = ACT_DRAW;
        end
        else
        begin
            case (code)
                CODE_USR_CLIP_A, CODE_USR_CLIP_B: act = ACT_USR_CLIP;
                CODE_SYS_CLIP:                    act = ACT_SYS_CLIP;
                CODE_LOCAL:                       act = ACT_LOCAL;
                default:
                begin
                    act      = ACT_NONE;
                    bad_code = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        target = seq_addr;
        case (jump)
            JMP_NEXT:   target = seq_addr;
            JMP_ASSIGN: target = link_addr;
            JMP_CALL:   target = link_addr;
            JMP_RETURN: target = flags.ret_valid ? ret_addr : seq_addr;
            default:    target = seq_addr;
        endcase
    end

    always_comb
    begin
        cur_addr_next    = cur_addr;
        ret_addr_next    = ret_addr;
        entry_count_next = entry_count;
        flags_next       = flags;

        result.table_index  = INDEX_W'(cur_addr >> LINK_SHIFT);
        result.action       = ACT_NONE;
        result.next_address = FIELD_ADDR_W'(cur_addr);
        result.status       = ST_END;
        result.error_flag   = flags.bad_seen;

        if (command == CMD_START)
        begin
            cur_addr_next        = load_addr;
            entry_count_next     = '0;
            flags_next.ret_valid = 1'b0;
            flags_next.running   = 1'b1;
            result.table_index   = INDEX_W'(load_addr >> LINK_SHIFT);
            result.next_address  = FIELD_ADDR_W'(load_addr);
            result.status        = ST_CONTINUE;
        end
        else if (!flags.running)
        begin
            result.status = ST_END;
        end
        else if (control_word[CTRL_END_BIT])
        begin
            flags_next.running = 1'b0;
            result.status      = ST_END;
        end
        else if (entry_count >= max_entries)
        begin
            flags_next.running = 1'b0;
            result.status      = ST_LIMIT;
        end
        else if (bad_code)
        begin
            flags_next.running  = 1'b0;
            flags_next.bad_seen = 1'b1;
            result.status       = ST_BAD;
            result.error_flag   = 1'b1;
        end
        else
        begin
            // one-level return: a call only saves when nothing is held
            if (jump == JMP_CALL && !flags.ret_valid)
            begin
                ret_addr_next        = seq_addr;
                flags_next.ret_valid = 1'b1;
            end
            if (jump == JMP_RETURN)
            begin
                flags_next.ret_valid = 1'b0;
            end
            cur_addr_next       = target;
            entry_count_next    = entry_count + COUNT_W'(1);
            result.action       = act;
            result.next_address = FIELD_ADDR_W'(target);
            result.status       = ST_CONTINUE;
        end
    end

endmodule
`default_nettype wire

>>> design/clseq_out_reg.sv
// Result output register with stream handshake.
`default_nettype none
module clseq_out_reg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                load,
    input  wire clseq_pkg::clseq_result_t            result,
    output logic                                     can_load,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [clseq_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import clseq_pkg::*;

    localparam int RES_W = $bits(clseq_result_t);

    logic          valid_reg;
    logic          valid_next;
    clseq_result_t data_reg;

    assign can_load = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    // pack first field lowest: table_index, action, next_address, status, error_flag
    assign m_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}},
                       data_reg.error_flag, data_reg.status, data_reg.next_address,
                       data_reg.action, data_reg.table_index};

endmodule
`default_nettype wire

>>> bench/tb_command_list_sequencer.sv
// Self-checking bench for command_list_sequencer: stream stimulus, APB setup and scoreboard.
module tb_command_list_sequencer;
    import clseq_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 80;
    localparam int REPORT_LIMIT = 10;

    localparam logic [3:0] CODE_DRAW_FIRST = 4'd0;
    localparam logic [3:0] CODE_DRAW_LAST  = 4'd7;
    localparam logic [3:0] CODE_BAD_FIRST  = 4'd12;
    localparam logic [3:0] CODE_BAD_LAST   = 4'd15;

    localparam logic [FIELD_ADDR_W-1:0] ADDR_TOP = '1;
    localparam logic [WORD_W-1:0]       LINK_TOP = '1;

    // result field positions in m_tdata
    localparam int RES_ACT_LSB  = INDEX_W;
    localparam int RES_NEXT_LSB = RES_ACT_LSB + 3;
    localparam int RES_ST_LSB   = RES_NEXT_LSB + FIELD_ADDR_W;
    localparam int RES_ERR_LSB  = RES_ST_LSB + 2;

    class walk_scoreboard;
        logic [FIELD_ADDR_W-1:0] cur_addr;
        logic [FIELD_ADDR_W-1:0] ret_addr;
        bit                      ret_valid;
        bit                      running;
        bit                      bad_seen;
        logic [COUNT_W-1:0]      entries_done;
        logic [COUNT_W-1:0]      entry_limit;
        clseq_result_t           expected_q[$];
        int                      errors;
        int                      walk_items;
        int                      results_seen;
        int                      status_hits[4];
        int                      action_hits[6];

        function new();
            cur_addr     = '0;
            ret_addr     = '0;
            ret_valid    = 1'b0;
            running      = 1'b0;
            bad_seen     = 1'b0;
            entries_done = '0;
            entry_limit  = MAX_ENTRIES_RESET;
            errors       = 0;
            walk_items   = 0;
            results_seen = 0;
        endfunction

        function void set_limit(logic [COUNT_W-1:0] value);
            entry_limit = value;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%s", msg);
        endfunction

        function void push(action_t act, logic [FIELD_ADDR_W-1:0] nxt, status_t st);
            clseq_result_t r;
            r.table_index  = cur_addr[FIELD_ADDR_W-1:LINK_SHIFT];
            r.action       = act;
            r.next_address = nxt;
            r.status       = st;
            r.error_flag   = bad_seen;
            expected_q.push_back(r);
        endfunction

        // one accepted input beat -> one expected result
        function void note_input(command_t cmd, logic [FIELD_ADDR_W-1:0] addr,
                                 logic [WORD_W-1:0] ctrl, logic [WORD_W-1:0] link);
            action_t                 act;
            jump_t                   jmp;
            logic [FIELD_ADDR_W-1:0] nxt;
            logic [FIELD_ADDR_W-1:0] seq_addr;
            logic [FIELD_ADDR_W-1:0] link_addr;
            seq_addr  = cur_addr + FIELD_ADDR_W'(ENTRY_SIZE);
            link_addr = FIELD_ADDR_W'(link);
            link_addr = link_addr << LINK_SHIFT;
            if (cmd == CMD_START)
            begin
                cur_addr     = addr;
                ret_valid    = 1'b0;
                entries_done = '0;
                running      = 1'b1;
                walk_items++;
                push(ACT_NONE, cur_addr, ST_CONTINUE);
                return;
            end
            if (!running)
            begin
                push(ACT_NONE, cur_addr, ST_END);
                return;
            end
            walk_items++;
            if (ctrl[CTRL_END_BIT])
            begin
                running = 1'b0;
                push(ACT_NONE, cur_addr, ST_END);
                return;
            end
            if (entries_done >= entry_limit)
            begin
                running = 1'b0;
                push(ACT_NONE, cur_addr, ST_LIMIT);
                return;
            end
            if (ctrl[CTRL_SKIP_BIT])
                act = ACT_SKIPPED;
            else if (ctrl[CTRL_CODE_HI] == 1'b0)
                act = ACT_DRAW;
            else
            begin
                case (code_t'(ctrl[CTRL_CODE_HI:0]))
                    CODE_USR_CLIP_A, CODE_USR_CLIP_B: act = ACT_USR_CLIP;
                    CODE_SYS_CLIP:                    act = ACT_SYS_CLIP;
                    CODE_LOCAL:                       act = ACT_LOCAL;
                    default:
                    begin
                        bad_seen = 1'b1;
                        running  = 1'b0;
                        push(ACT_NONE, cur_addr, ST_BAD);
                        return;
                    end
                endcase
            end
            jmp = jump_t'(ctrl[CTRL_JUMP_HI:CTRL_JUMP_LO]);
            case (jmp)
                JMP_NEXT:   nxt = seq_addr;
                JMP_ASSIGN: nxt = link_addr;
                JMP_CALL:
                begin
                    // one-level return: an already saved address is kept
                    if (!ret_valid)
                    begin
                        ret_addr  = seq_addr;
                        ret_valid = 1'b1;
                    end
                    nxt = link_addr;
                end
                default:
                begin
                    if (ret_valid)
                    begin
                        nxt       = ret_addr;
                        ret_valid = 1'b0;
                    end
                    else
                        nxt = seq_addr;
                end
            endcase
            push(act, nxt, ST_CONTINUE);
            cur_addr = nxt;
            entries_done++;
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data);
            clseq_result_t want;
            clseq_result_t got;
            got.table_index  = data[INDEX_W-1:0];
            got.action       = action_t'(data[RES_ACT_LSB +: 3]);
            got.next_address = data[RES_NEXT_LSB +: FIELD_ADDR_W];
            got.status       = status_t'(data[RES_ST_LSB +: 2]);
            got.error_flag   = data[RES_ERR_LSB];
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result beat %0d arrived with nothing pending", results_seen));
                return;
            end
            want = expected_q.pop_front();
            if (got.table_index != want.table_index || got.action != want.action ||
                got.next_address != want.next_address || got.status != want.status ||
                got.error_flag != want.error_flag)
            begin
                report($sformatf({"result beat %0d mismatch: index %h/%h action %0d/%0d ",
                                  "next %h/%h status %0d/%0d error %0b/%0b (exp/got)"},
                                 results_seen, want.table_index, got.table_index,
                                 want.action, got.action, want.next_address,
                                 got.next_address, want.status, got.status,
                                 want.error_flag, got.error_flag));
                return;
            end
            status_hits[want.status]++;
            action_hits[want.action]++;
        endfunction
    endclass

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr    = '0;
    logic [APB_DATA_W-1:0]   pwdata   = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata  = '0;
    logic                    s_tuser  = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;

    walk_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request  = 1'b0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    command_list_sequencer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver: random back-pressure, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor both streams and watch for a stuck run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_input(command_t'(s_tuser), s_tdata[FIELD_ADDR_W-1:0],
                              s_tdata[FIELD_ADDR_W +: WORD_W],
                              s_tdata[FIELD_ADDR_W+WORD_W +: WORD_W]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("FAIL command_list_sequencer");
                    $finish;
                end
            end
        end
    end

    task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_limit(value[COUNT_W-1:0]);
    endtask

    task automatic send_beat(command_t cmd, logic [FIELD_ADDR_W-1:0] addr,
                             logic [WORD_W-1:0] ctrl, logic [WORD_W-1:0] link);
        logic [IN_TDATA_W-1:0] beat;
        beat = '0;
        beat[FIELD_ADDR_W-1:0]             = addr;
        beat[FIELD_ADDR_W +: WORD_W]        = ctrl;
        beat[FIELD_ADDR_W+WORD_W +: WORD_W] = link;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= beat;
        do @(posedge clk); while (!s_tready);
    endtask

    // wait until every expected result is back and the block has gone quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] entry_word(bit end_bit, bit skip, jump_t jmp,
                                                     logic [3:0] code);
        logic [WORD_W-1:0] w;
        w = WORD_W'($urandom);
        w[CTRL_END_BIT]                = end_bit;
        w[CTRL_SKIP_BIT]               = skip;
        w[CTRL_JUMP_HI:CTRL_JUMP_LO]   = jmp;
        w[CTRL_CODE_HI:0]              = code;
        return w;
    endfunction

    // a start followed by a run of entries; ends early on an end bit or bad code
    task automatic random_list(int max_len);
        int         len;
        int         pick;
        bit         skip;
        bit         end_bit;
        logic [3:0] code;
        len = $urandom_range(max_len, 1);
        send_beat(CMD_START, FIELD_ADDR_W'($urandom), WORD_W'($urandom), WORD_W'($urandom));
        for (int i = 0; i < len; i++)
        begin
            pick    = $urandom_range(99);
            skip    = ($urandom_range(99) < 20);
            end_bit = (pick < 4);
            if (pick >= 4 && pick < 10)
                code = 4'($urandom_range(CODE_BAD_LAST, CODE_BAD_FIRST));
            else
                code = 4'($urandom_range(CODE_BAD_FIRST - 1, CODE_DRAW_FIRST));
            send_beat(CMD_ENTRY, FIELD_ADDR_W'($urandom), entry_word(end_bit, skip,
                      jump_t'($urandom_range(3)), code), WORD_W'($urandom));
            if (end_bit || (!skip && code >= CODE_BAD_FIRST))
                break;
        end
        // stray entries: ignored if the walk has already stopped
        if ($urandom_range(99) < 10)
            repeat ($urandom_range(2, 1))
                send_beat(CMD_ENTRY, FIELD_ADDR_W'($urandom), WORD_W'($urandom),
                          WORD_W'($urandom));
    endtask

    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk, limit at its reset value
        send_beat(CMD_ENTRY, ADDR_TOP, entry_word(1'b0, 1'b0, JMP_NEXT, CODE_DRAW_FIRST),
                  LINK_TOP);
        send_beat(CMD_START, ADDR_TOP, LINK_TOP, LINK_TOP);
        send_beat(CMD_ENTRY, '0, '0, '0);
        send_beat(CMD_ENTRY, '0, entry_word(1'b0, 1'b0, JMP_ASSIGN, CODE_DRAW_LAST), LINK_TOP);
        send_beat(CMD_ENTRY, '0, entry_word(1'b0, 1'b0, JMP_CALL, CODE_USR_CLIP_A), 16'h0010);
        send_beat(CMD_ENTRY, '0, entry_word(1'b0, 1'b0, JMP_CALL, CODE_SYS_CLIP), '0);
        send_beat(CMD_ENTRY, '0, entry_word(1'b0, 1'b0, JMP_RETURN, CODE_LOCAL), LINK_TOP);
        send_beat(CMD_ENTRY, '0, entry_word(1'b0, 1'b0, JMP_RETURN, CODE_USR_CLIP_B), '0);
        send_beat(CMD_ENTRY, '0, entry_word(1'b0, 1'b1, JMP_NEXT, CODE_BAD_LAST), '0);
        send_beat(CMD_ENTRY, '0, entry_word(1'b0, 1'b1, JMP_ASSIGN, CODE_BAD_FIRST), '0);
        send_beat(CMD_ENTRY, ADDR_TOP, '1, LINK_TOP);
        send_beat(CMD_ENTRY, '0, entry_word(1'b0, 1'b0, JMP_NEXT, CODE_DRAW_FIRST), '0);
        send_beat(CMD_START, '0, '0, '0);
        send_beat(CMD_ENTRY, '0, entry_word(1'b0, 1'b0, JMP_NEXT, CODE_BAD_FIRST), '0);
        send_beat(CMD_ENTRY, '0, entry_word(1'b0, 1'b0, JMP_NEXT, CODE_DRAW_FIRST), '0);
        // error flag stays set across a new start
        send_beat(CMD_START, 19'h00040, '0, '0);
        send_beat(CMD_ENTRY, '0, entry_word(1'b0, 1'b0, JMP_CALL, CODE_BAD_LAST), LINK_TOP);
        settle();

        // limit of one: one entry, then the walk stops
        apb_write(REG_MAX_ENTRIES, 32'd1);
        send_beat(CMD_START, FIELD_ADDR_W'($urandom), '0, '0);
        send_beat(CMD_ENTRY, '0, entry_word(1'b0, 1'b0, JMP_NEXT, CODE_DRAW_LAST), '0);
        send_beat(CMD_ENTRY, '0, entry_word(1'b0, 1'b0, JMP_NEXT, CODE_DRAW_LAST), '0);
        send_beat(CMD_ENTRY, '0, entry_word(1'b0, 1'b0, JMP_NEXT, CODE_DRAW_LAST), '0);
        settle();

        apb_write(REG_MAX_ENTRIES, 32'd7);
        send_idle_pct = 13;
        recv_idle_pct = 55;
        while (sb.walk_items < 190)
            random_list(12);
        settle();

        apb_write(REG_MAX_ENTRIES, 32'h0000_FFFF);
        send_idle_pct = 55;
        recv_idle_pct = 13;
        while (sb.walk_items < 370)
            random_list(30);
        settle();

        apb_write(REG_MAX_ENTRIES, 32'd25);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // long receiver hold while the sender keeps pushing
        hold_request = 1'b1;
        while (sb.walk_items < 535)
            random_list(30);
        settle();

        $display("covered %0d walk beats, %0d results: %0d end, %0d bad, %0d limit stops",
                 sb.walk_items, sb.results_seen, sb.status_hits[ST_END],
                 sb.status_hits[ST_BAD], sb.status_hits[ST_LIMIT]);
        $display("actions: %0d draw, %0d skipped, %0d user clip, %0d system clip, %0d local",
                 sb.action_hits[ACT_DRAW], sb.action_hits[ACT_SKIPPED],
                 sb.action_hits[ACT_USR_CLIP], sb.action_hits[ACT_SYS_CLIP],
                 sb.action_hits[ACT_LOCAL]);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("PASS command_list_sequencer");
        else
            $display("FAIL command_list_sequencer");
        $finish;
    end

endmodule
